FILE: rtl/core/marker_length_frame_deframer_core_macros.svh
// ============================================================================
// Assertion macros for the marker/length frame deframer
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ============================================================================
`ifndef MARKER_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH
`define MARKER_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mlfd_pkg.sv
// ============================================================================
// Marker/length frame deframer package
// Frame phases, configuration register indexes and fixed field widths.
// ============================================================================
package mlfd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_TAIL = 2'd3
    } phase_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_PATTERN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_LENGTH  = 2'd3;

    localparam int unsigned PATTERN_W   = 64;
    localparam int unsigned MARK_LEN_W  = 4;
    localparam int unsigned BODY_LEN_W  = 32;
    localparam int unsigned FIELD_IDX_W = 4;
    localparam int unsigned LEN_BYTES   = 4;

endpackage

FILE: rtl/core/marker_length_frame_deframer_core.sv
// ============================================================================
// Marker/length frame deframer core
// Hunts for a head marker in a byte stream, reads a 4-byte little-endian
// body length, passes the body bytes and checks an optional tail marker.
//
//   Channel   Ports                                   Direction  Moves
//   s_        s_valid s_ready s_in_byte               in         one stream byte
//   m_        m_valid m_ready m_has_data m_out_byte   out        body byte / frame end
//             m_frame_end m_tail_ok
//   cfg_      cfg_we cfg_index cfg_wdata              in         register write
//
// One byte is accepted per cycle unless a held result stalls it. A byte is held
// in the input register; the phase logic and head window compare, both
// combinational, then load the result register, so each result passes through
// the input register and then the result register.
// Reset is synchronous and active low; it resets the configuration, valid and
// frame state registers and restarts the hunt. A valid result holds while
// m_ready is low; an empty input register takes one more byte, then s_ready drops.
// ============================================================================
`include "marker_length_frame_deframer_core_macros.svh"

module marker_length_frame_deframer_core
    import mlfd_pkg::*;
#(
    parameter int unsigned MAX_HEAD_BYTES = 8,
    parameter int unsigned MAX_TAIL_BYTES = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_in_byte,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_has_data,
    output logic [7:0]             m_out_byte,
    output logic                   m_frame_end,
    output logic                   m_tail_ok
);

    localparam int unsigned WIN_W = 8 * MAX_HEAD_BYTES;
    localparam int unsigned LEN_W = $clog2(MAX_HEAD_BYTES + 1);

    // Configuration registers.
    logic [PATTERN_W-1:0]  head_pattern_reg;
    logic [MARK_LEN_W-1:0] head_length_reg;
    logic [PATTERN_W-1:0]  tail_pattern_reg;
    logic [MARK_LEN_W-1:0] tail_length_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state.
    phase_t                 phase_reg, phase_next;
    logic [WIN_W-1:0]       head_window_reg, head_window_next;
    logic [LEN_W-1:0]       window_fill_reg, window_fill_next;
    logic [BODY_LEN_W-1:0]  length_accum_reg, length_accum_next;
    logic [BODY_LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [FIELD_IDX_W-1:0] field_index_reg, field_index_next;
    logic                   tail_mismatch_reg, tail_mismatch_next;

    // Result register.
    logic       m_valid_reg, m_valid_next;
    logic       m_has_data_reg, m_has_data_next;
    logic [7:0] m_out_byte_reg, m_out_byte_next;
    logic       m_frame_end_reg, m_frame_end_next;
    logic       m_tail_ok_reg, m_tail_ok_next;

    logic                   proc_fire;
    logic [LEN_W-1:0]       head_len_eff;
    logic [MARK_LEN_W-1:0]  tail_len_eff;
    logic [WIN_W-1:0]       window_shifted;
    logic [LEN_W-1:0]       fill_inc;
    logic                   head_match;
    logic [BODY_LEN_W-1:0]  accum_merged;
    logic [FIELD_IDX_W-1:0] index_inc;
    logic [7:0]             tail_want;

    assign proc_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    assign m_valid     = m_valid_reg;
    assign m_has_data  = m_has_data_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_frame_end = m_frame_end_reg;
    assign m_tail_ok   = m_tail_ok_reg;

    // Marker lengths outside the supported range are clamped.
    always_comb begin
        if (head_length_reg == '0) begin
            head_len_eff = LEN_W'(1);
        end else if (head_length_reg > MARK_LEN_W'(MAX_HEAD_BYTES)) begin
            head_len_eff = LEN_W'(MAX_HEAD_BYTES);
        end else begin
            head_len_eff = LEN_W'(head_length_reg);
        end
        if (tail_length_reg > MARK_LEN_W'(MAX_TAIL_BYTES)) begin
            tail_len_eff = MARK_LEN_W'(MAX_TAIL_BYTES);
        end else begin
            tail_len_eff = tail_length_reg;
        end
    end

    assign window_shifted = {in_byte_reg, head_window_reg[WIN_W-1:8]};
    assign fill_inc = (window_fill_reg < LEN_W'(MAX_HEAD_BYTES)) ?
                      window_fill_reg + LEN_W'(1) : window_fill_reg;
    assign accum_merged = length_accum_reg |
                          (BODY_LEN_W'(in_byte_reg) << {field_index_reg[1:0], 3'b000});
    assign index_inc = field_index_reg + FIELD_IDX_W'(1);
    assign tail_want = tail_pattern_reg[{field_index_reg[2:0], 3'b000} +: 8];

    mlfd_head_match #(
        .MAX_HEAD_BYTES(MAX_HEAD_BYTES)
    ) u_head_match (
        .window       (window_shifted),
        .head_pattern (head_pattern_reg),
        .head_len     (head_len_eff),
        .match        (head_match)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_pattern_reg <= '0;
            head_length_reg  <= MARK_LEN_W'(1);
            tail_pattern_reg <= '0;
            tail_length_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HEAD_PATTERN: head_pattern_reg <= cfg_wdata;
                CFG_HEAD_LENGTH:  head_length_reg  <= cfg_wdata[MARK_LEN_W-1:0];
                CFG_TAIL_PATTERN: tail_pattern_reg <= cfg_wdata;
                CFG_TAIL_LENGTH:  tail_length_reg  <= cfg_wdata[MARK_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase logic and result formation.
    always_comb begin
        phase_next         = phase_reg;
        head_window_next   = head_window_reg;
        window_fill_next   = window_fill_reg;
        length_accum_next  = length_accum_reg;
        bytes_left_next    = bytes_left_reg;
        field_index_next   = field_index_reg;
        tail_mismatch_next = tail_mismatch_reg;

        m_valid_next     = m_valid_reg && !m_ready;
        m_has_data_next  = m_has_data_reg;
        m_out_byte_next  = m_out_byte_reg;
        m_frame_end_next = m_frame_end_reg;
        m_tail_ok_next   = m_tail_ok_reg;

        if (proc_fire) begin
            case (phase_reg)
                PH_HUNT: begin
                    head_window_next = window_shifted;
                    window_fill_next = fill_inc;
                    if ((fill_inc >= head_len_eff) && head_match) begin
                        phase_next        = PH_LEN;
                        head_window_next  = '0;
                        window_fill_next  = '0;
                        length_accum_next = '0;
                        field_index_next  = '0;
                    end
                end
                PH_LEN: begin
                    length_accum_next = accum_merged;
                    field_index_next  = index_inc;
                    if (field_index_reg == FIELD_IDX_W'(LEN_BYTES - 1)) begin
                        bytes_left_next    = accum_merged;
                        field_index_next   = '0;
                        tail_mismatch_next = 1'b0;
                        if (accum_merged != '0) begin
                            phase_next = PH_BODY;
                        end else if (tail_len_eff != '0) begin
                            phase_next = PH_TAIL;
                        end else begin
                            // Empty body and no tail: the frame ends here.
                            phase_next        = PH_HUNT;
                            length_accum_next = '0;
                            bytes_left_next   = '0;
                            m_valid_next      = 1'b1;
                            m_has_data_next   = 1'b0;
                            m_out_byte_next   = '0;
                            m_frame_end_next  = 1'b1;
                            m_tail_ok_next    = 1'b1;
                        end
                    end
                end
                PH_BODY: begin
                    bytes_left_next  = bytes_left_reg - BODY_LEN_W'(1);
                    m_valid_next     = 1'b1;
                    m_has_data_next  = 1'b1;
                    m_out_byte_next  = in_byte_reg;
                    m_frame_end_next = 1'b0;
                    m_tail_ok_next   = 1'b0;
                    if (bytes_left_reg == BODY_LEN_W'(1)) begin
                        field_index_next   = '0;
                        tail_mismatch_next = 1'b0;
                        if (tail_len_eff != '0) begin
                            phase_next = PH_TAIL;
                        end else begin
                            phase_next        = PH_HUNT;
                            length_accum_next = '0;
                            m_frame_end_next  = 1'b1;
                            m_tail_ok_next    = 1'b1;
                        end
                    end
                end
                PH_TAIL: begin
                    tail_mismatch_next = tail_mismatch_reg || (tail_want != in_byte_reg);
                    field_index_next   = index_inc;
                    if (index_inc >= tail_len_eff) begin
                        phase_next         = PH_HUNT;
                        head_window_next   = '0;
                        window_fill_next   = '0;
                        length_accum_next  = '0;
                        bytes_left_next    = '0;
                        field_index_next   = '0;
                        tail_mismatch_next = 1'b0;
                        m_valid_next       = 1'b1;
                        m_has_data_next    = 1'b0;
                        m_out_byte_next    = '0;
                        m_frame_end_next   = 1'b1;
                        m_tail_ok_next     = !(tail_mismatch_reg || (tail_want != in_byte_reg));
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            phase_reg         <= PH_HUNT;
            head_window_reg   <= '0;
            window_fill_reg   <= '0;
            length_accum_reg  <= '0;
            bytes_left_reg    <= '0;
            field_index_reg   <= '0;
            tail_mismatch_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            m_valid_reg       <= m_valid_next;
            phase_reg         <= phase_next;
            head_window_reg   <= head_window_next;
            window_fill_reg   <= window_fill_next;
            length_accum_reg  <= length_accum_next;
            bytes_left_reg    <= bytes_left_next;
            field_index_reg   <= field_index_next;
            tail_mismatch_reg <= tail_mismatch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
        m_has_data_reg  <= m_has_data_next;
        m_out_byte_reg  <= m_out_byte_next;
        m_frame_end_reg <= m_frame_end_next;
        m_tail_ok_reg   <= m_tail_ok_next;
    end

    `MLFD_ASSERT_SAME(a_mid_frame_has_data, m_valid && !m_frame_end, m_has_data && !m_tail_ok,
        "result without frame end must carry a body byte")
    `MLFD_ASSERT_SAME(a_body_count_live, phase_reg == PH_BODY, bytes_left_reg != '0,
        "body phase entered with no bytes left")
    `MLFD_ASSERT_SAME(a_len_index_range, phase_reg == PH_LEN,
        field_index_reg < FIELD_IDX_W'(LEN_BYTES), "length byte index out of range")
    `MLFD_ASSERT_NEXT(a_end_restarts_hunt, proc_fire && m_valid_next && m_frame_end_next,
        phase_reg == PH_HUNT && window_fill_reg == '0, "frame end did not restart the hunt")

endmodule

FILE: rtl/core/mlfd_head_match.sv
// ============================================================================
// Head marker window compare
// Compares the newest head_len bytes of the sliding window with the low
// bytes of the head pattern.
// ============================================================================
module mlfd_head_match
    import mlfd_pkg::*;
#(
    parameter int unsigned MAX_HEAD_BYTES = 8
) (
    input  logic [8*MAX_HEAD_BYTES-1:0]         window,
    input  logic [PATTERN_W-1:0]                head_pattern,
    input  logic [$clog2(MAX_HEAD_BYTES+1)-1:0] head_len,
    output logic                                match
);

    localparam int unsigned WIN_W = 8 * MAX_HEAD_BYTES;
    localparam int unsigned LEN_W = $clog2(MAX_HEAD_BYTES + 1);

    logic [LEN_W-1:0] gap;
    logic [WIN_W-1:0] newest;

    // The newest bytes sit at the top of the window; bring them down to byte 0.
    assign gap    = LEN_W'(MAX_HEAD_BYTES) - head_len;
    assign newest = window >> {gap, 3'b000};

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < MAX_HEAD_BYTES; k++) begin
            if ((LEN_W'(k) < head_len) && (newest[8*k +: 8] != head_pattern[8*k +: 8])) begin
                match = 1'b0;
            end
        end
    end

endmodule

FILE: tb/tb_top.sv
// ============================================================================
// Testbench for the marker/length frame deframer core
// Feeds byte streams of well-formed frames, frames with spoiled tails, cut-off
// heads and loose noise under several register settings and idling patterns.
// A built-in deframer predicts every result, which is checked field by field
// against the result channel in arrival order.
// ============================================================================
module tb_top;
    import mlfd_pkg::*;

    localparam int unsigned LIMIT_CYCLES     = 400000;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned HOLD_CYCLES      = 300;
    localparam int unsigned BYTES_PER_CONFIG = 120;
    localparam int unsigned REPORT_MAX       = 10;

    typedef struct packed {
        logic       has_data;
        logic [7:0] out_byte;
        logic       frame_end;
        logic       tail_ok;
    } deframe_out_t;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] window;
        logic [3:0]  fill;
        logic [31:0] accum;
        logic [31:0] left;
        logic [3:0]  idx;
        logic        mismatch;
    } deframer_state_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_in_byte = 8'h00;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic                   m_has_data;
    logic [7:0]             m_out_byte;
    logic                   m_frame_end;
    logic                   m_tail_ok;

    // Register copies shared by the predictor and the stimulus generator.
    logic [63:0] head_pat = '0;
    logic [3:0]  head_len = 4'd1;
    logic [63:0] tail_pat = '0;
    logic [3:0]  tail_len = 4'd0;

    deframer_state_t model_st;
    deframer_state_t gen_st;
    deframe_out_t    accepted_res;
    deframe_out_t    deframed_q[$];
    logic [7:0]      byte_q[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned bytes_made     = 0;
    int unsigned bytes_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned frames_seen    = 0;
    int unsigned bad_tails      = 0;
    int unsigned settings_used  = 0;

    marker_length_frame_deframer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_has_data  (m_has_data),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .m_tail_ok   (m_tail_ok)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned head_bytes();
        if (head_len == 4'd0) return 1;
        if (head_len > 4'd8) return 8;
        return head_len;
    endfunction

    function automatic int unsigned tail_bytes();
        if (tail_len > 4'd8) return 8;
        return tail_len;
    endfunction

    function automatic deframer_state_t hunt_state();
        deframer_state_t st;
        st = '0;
        st.phase = PH_HUNT;
        return st;
    endfunction

    // Advances one deframer state by one stream byte; returns 1 when the byte
    // produces a result.
    function automatic bit deframe_step(inout deframer_state_t st, input logic [7:0] b,
                                        output deframe_out_t r);
        int unsigned n;
        logic [63:0] mask;
        logic [7:0]  want;
        r = '0;
        case (st.phase)
            PH_HUNT: begin
                n = head_bytes();
                mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
                st.window = {b, st.window[63:8]};
                if (st.fill < 4'd8) st.fill = st.fill + 4'd1;
                if (st.fill >= n &&
                    ((st.window >> (64 - 8 * n)) & mask) == (head_pat & mask)) begin
                    st = hunt_state();
                    st.phase = PH_LEN;
                end
                return 1'b0;
            end
            PH_LEN: begin
                st.accum = st.accum | ({24'd0, b} << (8 * st.idx[1:0]));
                st.idx = st.idx + 4'd1;
                if (st.idx < LEN_BYTES) return 1'b0;
                st.left = st.accum;
                st.idx = '0;
                st.mismatch = 1'b0;
                if (st.left != 32'd0) begin
                    st.phase = PH_BODY;
                    return 1'b0;
                end
                if (tail_bytes() != 0) begin
                    st.phase = PH_TAIL;
                    return 1'b0;
                end
                st = hunt_state();
                r.frame_end = 1'b1;
                r.tail_ok = 1'b1;
                return 1'b1;
            end
            PH_BODY: begin
                st.left = st.left - 32'd1;
                r.has_data = 1'b1;
                r.out_byte = b;
                if (st.left != 32'd0) return 1'b1;
                st.idx = '0;
                st.mismatch = 1'b0;
                if (tail_bytes() != 0) begin
                    st.phase = PH_TAIL;
                    return 1'b1;
                end
                st = hunt_state();
                r.frame_end = 1'b1;
                r.tail_ok = 1'b1;
                return 1'b1;
            end
            default: begin
                want = tail_pat[8 * st.idx[2:0] +: 8];
                if (want != b) st.mismatch = 1'b1;
                st.idx = st.idx + 4'd1;
                if (st.idx < tail_bytes()) return 1'b0;
                r.frame_end = 1'b1;
                r.tail_ok = !st.mismatch;
                st = hunt_state();
                return 1'b1;
            end
        endcase
    endfunction

    // Queues one byte. The generator tracks the deframer state so that a
    // length field that noise happens to open stays below 512.
    task automatic emit(input logic [7:0] b);
        deframe_out_t unused;
        logic [7:0]   v;
        v = b;
        if (gen_st.phase == PH_LEN) begin
            if (gen_st.idx == 4'd1) v = v & 8'h01;
            else if (gen_st.idx >= 4'd2) v = 8'h00;
        end
        void'(deframe_step(gen_st, v, unused));
        byte_q.push_back(v);
        bytes_made++;
    endtask

    task automatic send_frame(input int unsigned body_len, input bit spoil_tail);
        int unsigned nh;
        int unsigned nt;
        int unsigned bad_at;
        logic [31:0] len_field;
        logic [7:0]  tb;
        nh = head_bytes();
        nt = tail_bytes();
        len_field = body_len;
        bad_at = (nt == 0) ? 0 : $urandom_range(nt - 1);
        while (gen_st.phase != PH_HUNT) emit($urandom_range(255));
        for (int i = 0; i < nh; i++) emit(head_pat[8 * i +: 8]);
        for (int i = 0; i < 4; i++) emit(len_field[8 * i +: 8]);
        for (int i = 0; i < body_len; i++) emit($urandom_range(255));
        for (int i = 0; i < nt; i++) begin
            tb = tail_pat[8 * i +: 8];
            if (spoil_tail && i == bad_at) tb = tb ^ (8'h01 << $urandom_range(7));
            emit(tb);
        end
    endtask

    function automatic int unsigned pick_body_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2) return $urandom_range(300, 200);
        if (r < 17) return $urandom_range(40, 13);
        return $urandom_range(12);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [63:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            CFG_HEAD_PATTERN: head_pat = value;
            CFG_HEAD_LENGTH:  head_len = value[3:0];
            CFG_TAIL_PATTERN: tail_pat = value;
            default:          tail_len = value[3:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued byte has gone in and every predicted result has
    // come out, then lets bytes without a result drain through the pipeline.
    task automatic wait_quiet();
        do begin
            while (byte_q.size() != 0 || s_valid || deframed_q.size() != 0) @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end while (byte_q.size() != 0 || s_valid || deframed_q.size() != 0);
    endtask

    task automatic pick_setting(input int unsigned which);
        logic [63:0] hp;
        logic [63:0] tp;
        logic [3:0]  hl;
        logic [3:0]  tl;
        hp = {$urandom, $urandom};
        tp = {$urandom, $urandom};
        hl = $urandom_range(15);
        tl = $urandom_range(15);
        case (which)
            0: begin hl = 4'd8; tl = 4'd15; end
            1: begin hl = 4'd1; tl = 4'd0; hp = '0; end
            2: begin hl = 4'd0; tl = 4'd8; hp = '1; tp = '0; end
            3: begin hl = 4'd15; tl = 4'd1; tp = '1; end
            default: ;
        endcase
        write_reg(CFG_HEAD_PATTERN, hp);
        write_reg(CFG_HEAD_LENGTH, {60'd0, hl});
        write_reg(CFG_TAIL_PATTERN, tp);
        write_reg(CFG_TAIL_LENGTH, {60'd0, tl});
        settings_used++;
    endtask

    task automatic random_traffic(input int unsigned amount);
        int unsigned start;
        int unsigned pick;
        int unsigned cut;
        start = bytes_made;
        while (bytes_made - start < amount) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(pick_body_len(), 1'b0);
            end else if (pick < 80) begin
                send_frame(pick_body_len(), 1'b1);
            end else if (pick < 90) begin
                // Head cut short, then loose bytes.
                cut = $urandom_range(head_bytes() - 1);
                for (int i = 0; i < cut; i++) emit(head_pat[8 * i +: 8]);
                repeat ($urandom_range(4, 1)) emit($urandom_range(255));
            end else begin
                repeat ($urandom_range(8, 1)) emit($urandom_range(255));
            end
        end
    endtask

    // Sender: a transaction stays offered unchanged until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (deframe_step(model_st, s_in_byte, accepted_res))
                    deframed_q.push_back(accepted_res);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= byte_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        deframe_out_t got;
        deframe_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_has_data, m_out_byte, m_frame_end, m_tail_ok};
            results_seen++;
            if (got.frame_end) frames_seen++;
            if (got.frame_end && !got.tail_ok) bad_tails++;
            if (deframed_q.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result: has_data=%0b out_byte=%02h %s=%0b tail_ok=%0b",
                             got.has_data, got.out_byte, "frame_end", got.frame_end,
                             got.tail_ok);
            end else begin
                want = deframed_q.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("mismatch: expected has_data=%0b out_byte=%02h %s=%0b tail_ok=%0b",
                                 want.has_data, want.out_byte, "frame_end", want.frame_end,
                                 want.tail_ok);
                        $display("          got      has_data=%0b out_byte=%02h %s=%0b tail_ok=%0b",
                                 got.has_data, got.out_byte, "frame_end", got.frame_end,
                                 got.tail_ok);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int unsigned send_mode[4];
        int unsigned recv_mode[4];
        send_mode = '{0, 79, 0, 29};
        recv_mode = '{0, 0, 79, 29};
        model_st = hunt_state();
        gen_st   = hunt_state();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: one-byte zero head, no tail.
        emit(8'h00); emit(8'h01); emit(8'h00); emit(8'h00); emit(8'h00); emit(8'hFF);
        emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h00);
        wait_quiet();

        // A head length of zero acts as one byte; empty body straight into the
        // tail, first with a spoiled tail and then a good one right after.
        write_reg(CFG_HEAD_LENGTH, 64'd0);
        write_reg(CFG_HEAD_PATTERN, 64'h0123_4567_89AB_CDC3);
        write_reg(CFG_TAIL_LENGTH, 64'd2);
        write_reg(CFG_TAIL_PATTERN, 64'hFFFF_FFFF_FFFF_7E81);
        emit(8'hC3); emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h00);
        emit(8'h81); emit(8'h00);
        emit(8'hC3); emit(8'h00); emit(8'h00); emit(8'h00); emit(8'h00);
        emit(8'h81); emit(8'h7E);
        wait_quiet();

        // Oversized head length saturates to eight bytes. The frame stops in
        // the middle of its tail, and the tail is then shortened.
        write_reg(CFG_HEAD_LENGTH, 64'd15);
        write_reg(CFG_HEAD_PATTERN, '1);
        write_reg(CFG_TAIL_LENGTH, 64'd3);
        write_reg(CFG_TAIL_PATTERN, 64'h0000_0000_0033_2211);
        send_frame(1, 1'b0);
        void'(byte_q.pop_back());
        // The generator copy sits two bytes into the tail, like the block.
        gen_st       = hunt_state();
        gen_st.phase = PH_TAIL;
        gen_st.idx   = 4'd2;
        bytes_made--;
        wait_quiet();
        write_reg(CFG_TAIL_LENGTH, 64'd1);
        emit(8'h33);
        wait_quiet();

        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct  = send_mode[mode];
            recv_stall_pct = recv_mode[mode];
            for (int s = 0; s < 3; s++) begin
                wait_quiet();
                pick_setting(mode * 3 + s);
                if (mode == 0 && s == 1) hold_req++;
                random_traffic(BYTES_PER_CONFIG);
            end
        end
        wait_quiet();

        $display("Covered %0d stream bytes, %0d random register settings, four idling patterns.",
                 bytes_accepted, settings_used);
        $display("Checked %0d results: %0d frame ends, %0d of them with a bad tail; %0d errors.",
                 results_seen, frames_seen, bad_tails, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/mlfd_pkg.sv
rtl/core/mlfd_head_match.sv
rtl/core/marker_length_frame_deframer_core.sv
tb/tb_top.sv
